[design/rrp_pkg.sv]
package rrp_pkg;

  // Default build values
  localparam int FRAME_LIMIT_DEF = 30;
  localparam int Q_DEPTH_DEF     = 2;

  // Fill index and position widths
  localparam int IDX_W = 5;
  localparam int CNT_W = IDX_W + 1;

  // Frame layout
  localparam int HDR_LEN   = 4;
  localparam int TAIL_MIN  = 8;
  localparam int RPT_FIRST = 8;
  localparam int RPT_LAST  = 14;
  localparam int RPT_LEN   = RPT_LAST - RPT_FIRST + 1;

  // Header and tail byte patterns, in arrival order
  localparam logic [7:0] HDR_B0  = 8'hF4;
  localparam logic [7:0] HDR_B1  = 8'hF3;
  localparam logic [7:0] HDR_B2  = 8'hF2;
  localparam logic [7:0] HDR_B3  = 8'hF1;
  localparam logic [7:0] TAIL_B0 = 8'hF8;
  localparam logic [7:0] TAIL_B1 = 8'hF7;
  localparam logic [7:0] TAIL_B2 = 8'hF6;
  localparam logic [7:0] TAIL_B3 = 8'hF5;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  target_state;
    logic [15:0] moving_distance;
    logic [7:0]  moving_level;
    logic [15:0] static_distance;
    logic [7:0]  static_level;
  } out_item_t;

  // Raw report bytes, entry 0 is frame offset 8
  typedef logic [RPT_LEN-1:0][7:0] rpt_bytes_t;

  // Front to queue
  typedef struct packed {
    logic       push;
    rpt_bytes_t bytes;
  } q_wr_t;

  // Queue to front and back
  typedef struct packed {
    logic       valid;
    logic       full;
    rpt_bytes_t bytes;
  } q_rd_t;

endpackage

[design/rrp_chan_if.sv]
// Input byte channel
interface rrp_in_if;
  logic             valid;
  logic             ready;
  rrp_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Report channel
interface rrp_out_if;
  logic               valid;
  logic               ready;
  rrp_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/rrp_front.sv]
module rrp_front #(
  parameter int FRAME_LIMIT = rrp_pkg::FRAME_LIMIT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  rrp_in_if.sink         in_chan,
  input  logic           q_full,
  output rrp_pkg::q_wr_t q_wr
);
  import rrp_pkg::*;

  logic [IDX_W-1:0]  fill_r, fill_nxt;
  logic [2:0][7:0]   hdr_r, hdr_nxt;   // frame offsets 0..2
  logic [2:0][7:0]   hist_r, hist_nxt; // last three bytes, entry 0 newest
  rpt_bytes_t        rpt_r, rpt_nxt;   // frame offsets 8..14

  logic              accept;
  logic [7:0]        rx;
  logic [IDX_W-1:0]  pos;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  n_eff;
  logic              hdr_ok;
  logic              tail_hit;

  assign in_chan.ready = !q_full;

  // Classify the incoming byte against the stored frame
  always_comb begin
    accept   = in_chan.valid && in_chan.ready;
    rx       = in_chan.data.rx_byte;
    pos      = ({1'b0, fill_r} >= CNT_W'(FRAME_LIMIT)) ? '0 : fill_r;
    n        = CNT_W'({1'b0, pos}) + CNT_W'(1);

    hdr_nxt  = hdr_r;
    if (pos < IDX_W'(3)) begin
      hdr_nxt[pos[1:0]] = rx;
    end
    hdr_ok   = (hdr_r[0] == HDR_B0) && (hdr_r[1] == HDR_B1) &&
               (hdr_r[2] == HDR_B2) && (rx == HDR_B3);

    // Bad header: drop the oldest byte and keep three
    n_eff    = n;
    if (n == CNT_W'(HDR_LEN) && !hdr_ok) begin
      hdr_nxt[0] = hdr_r[1];
      hdr_nxt[1] = hdr_r[2];
      hdr_nxt[2] = rx;
      n_eff      = CNT_W'(HDR_LEN - 1);
    end

    rpt_nxt  = rpt_r;
    if (pos >= IDX_W'(RPT_FIRST) && pos <= IDX_W'(RPT_LAST)) begin
      rpt_nxt[3'(pos - IDX_W'(RPT_FIRST))] = rx;
    end

    hist_nxt = {hist_r[1], hist_r[0], rx};

    tail_hit = (n_eff >= CNT_W'(TAIL_MIN)) &&
               (hist_r[2] == TAIL_B0) && (hist_r[1] == TAIL_B1) &&
               (hist_r[0] == TAIL_B2) && (rx == TAIL_B3);

    if (tail_hit || n_eff >= CNT_W'(FRAME_LIMIT)) begin
      fill_nxt = '0;
    end else begin
      fill_nxt = n_eff[IDX_W-1:0];
    end

    q_wr.push  = accept && tail_hit;
    q_wr.bytes = rpt_nxt;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      hdr_r  <= '0;
      rpt_r  <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
      hdr_r  <= hdr_nxt;
      rpt_r  <= rpt_nxt;
    end
  end

  // Byte history, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      hist_r <= hist_nxt;
    end
  end

endmodule

[design/rrp_queue.sv]
module rrp_queue #(
  parameter int DEPTH = rrp_pkg::Q_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rrp_pkg::q_wr_t q_wr,
  input  logic           pop,
  output rrp_pkg::q_rd_t q_rd
);
  import rrp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CT_W  = $clog2(DEPTH + 1);

  rpt_bytes_t        mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CT_W-1:0]   cnt_r;

  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.full  = (cnt_r == CT_W'(DEPTH));
  assign q_rd.bytes = mem_r[rd_ptr_r];

  // Report storage
  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.bytes;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (q_wr.push && !pop) begin
        cnt_r <= cnt_r + CT_W'(1);
      end else if (pop && !q_wr.push) begin
        cnt_r <= cnt_r - CT_W'(1);
      end
    end
  end

endmodule

[design/rrp_back.sv]
module rrp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  rrp_pkg::q_rd_t q_rd,
  output logic           pop,
  rrp_out_if.source      out_chan
);
  import rrp_pkg::*;

  logic       out_valid_r;
  out_item_t  out_data_r;
  out_item_t  packed_item;

  // Assemble little-endian fields from raw frame bytes
  always_comb begin
    packed_item.target_state    = q_rd.bytes[0];
    packed_item.moving_distance = {q_rd.bytes[2], q_rd.bytes[1]};
    packed_item.moving_level    = q_rd.bytes[3];
    packed_item.static_distance = {q_rd.bytes[5], q_rd.bytes[4]};
    packed_item.static_level    = q_rd.bytes[6];
  end

  assign pop            = q_rd.valid && (!out_valid_r || out_chan.ready);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= packed_item;
    end
  end

endmodule

[design/radar_report_frame_parser.sv]
// Radar report frame parser.
// in_chan carries one received serial byte per request (rx_byte). The parser
// hunts for the header F4 F3 F2 F1, collects the frame and, when the tail
// F8 F7 F6 F5 arrives at eight or more bytes, issues one report request on
// out_chan with the target state, moving/static distance (little endian)
// and moving/static energy taken from frame offsets 8 to 14.
// Throughput: one byte per cycle; in_chan.ready is high whenever the report
// queue (Q_DEPTH entries) has room, so input never waits on the output unless
// Q_DEPTH + 1 reports are pending.
// After the tail byte is accepted, the report is written into the queue and
// then into the output register, which drives out_chan.valid.
// Reset (rst_n low, synchronous): the stored header and report bytes clear to
// zero, the fill restarts at offset zero and both queue and output register empty.
// When the receiver stalls, the current report holds on out_chan and later
// reports wait in the queue; once it fills, in_chan.ready drops.
module radar_report_frame_parser #(
  parameter int FRAME_LIMIT = rrp_pkg::FRAME_LIMIT_DEF,
  parameter int Q_DEPTH     = rrp_pkg::Q_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rrp_in_if.sink    in_chan,
  rrp_out_if.source out_chan
);
  import rrp_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_pop;

  rrp_front #(
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_rd.full),
    .q_wr    (q_wr)
  );

  rrp_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .q_rd  (q_rd)
  );

  rrp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_rd     (q_rd),
    .pop      (q_pop),
    .out_chan (out_chan)
  );

  // Queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> !q_rd.full)
    else $error("report queue overflow");

  // A pushed report is pending in the next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |=> q_rd.valid)
    else $error("pushed report lost");

  // Only pop an occupied queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_rd.valid)
    else $error("report queue underflow");

  // Reset empties the output
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("output valid after reset");

endmodule
